@@ rtl/core/bsp_pkg.sv @@
// ----------------------------------------------------------------------------
// bsp_pkg - shared definitions for the cubic B-spline point unit
// Register indexes and configuration port sizing.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int NUM_AXES = 3;
  localparam int NUM_REGS = 4;

  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_LSB = 3;

  typedef enum logic [1:0] {
    REG_CTRL_A = 2'd0,
    REG_CTRL_B = 2'd1,
    REG_CTRL_C = 2'd2,
    REG_CTRL_D = 2'd3
  } reg_idx_t;

endpackage

@@ rtl/core/bsp_in_if.sv @@
// ----------------------------------------------------------------------------
// bsp_in_if - curve parameter channel
// Valid/ready channel carrying one curve parameter per transaction.
// ----------------------------------------------------------------------------
interface bsp_in_if #(
  parameter int T_WIDTH = 17
);
  logic               valid;
  logic               ready;
  logic [T_WIDTH-1:0] t_param;

  modport source (output valid, output t_param, input ready);
  modport sink   (input valid, input t_param, output ready);
endinterface

@@ rtl/core/bsp_out_if.sv @@
// ----------------------------------------------------------------------------
// bsp_out_if - curve point channel
// Valid/ready channel carrying one 3D point per transaction.
// ----------------------------------------------------------------------------
interface bsp_out_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;

  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

@@ rtl/core/bsp_cfg.sv @@
// ----------------------------------------------------------------------------
// bsp_cfg - control point registers and polynomial coefficients
// APB-style register file for the four control points. Per axis it forms the
// power-basis coefficients of the segment and registers them.
// ----------------------------------------------------------------------------
module bsp_cfg #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bsp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bsp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bsp_pkg::APB_DATA_W-1:0]    prdata,
  output logic signed [COORD_WIDTH+3:0]     k3_o [bsp_pkg::NUM_AXES],
  output logic signed [COORD_WIDTH+3:0]     k2_o [bsp_pkg::NUM_AXES],
  output logic signed [COORD_WIDTH+3:0]     k1_o [bsp_pkg::NUM_AXES],
  output logic [COORD_WIDTH+2:0]            kc_o [bsp_pkg::NUM_AXES]
);

  localparam int CW = COORD_WIDTH;
  localparam int KW = CW + 4;
  localparam int PW = 3 * CW;
  localparam logic signed [KW-1:0] KC_OFS = KW'(3 * (2 ** CW) + 3);

  logic [PW-1:0]     pt_a_r, pt_b_r, pt_c_r, pt_d_r;
  logic              wr_en;
  bsp_pkg::reg_idx_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = bsp_pkg::reg_idx_t'(paddr[bsp_pkg::REG_IDX_LSB +: 2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_a_r <= '0;
      pt_b_r <= '0;
      pt_c_r <= '0;
      pt_d_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        bsp_pkg::REG_CTRL_A: pt_a_r <= pwdata[PW-1:0];
        bsp_pkg::REG_CTRL_B: pt_b_r <= pwdata[PW-1:0];
        bsp_pkg::REG_CTRL_C: pt_c_r <= pwdata[PW-1:0];
        bsp_pkg::REG_CTRL_D: pt_d_r <= pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bsp_pkg::REG_CTRL_A: prdata = bsp_pkg::APB_DATA_W'(pt_a_r);
      bsp_pkg::REG_CTRL_B: prdata = bsp_pkg::APB_DATA_W'(pt_b_r);
      bsp_pkg::REG_CTRL_C: prdata = bsp_pkg::APB_DATA_W'(pt_c_r);
      bsp_pkg::REG_CTRL_D: prdata = bsp_pkg::APB_DATA_W'(pt_d_r);
      default:             prdata = '0;
    endcase
  end

  for (genvar ax = 0; ax < bsp_pkg::NUM_AXES; ax++) begin : g_axis
    logic signed [CW-1:0] ca, cb, cc, cd;
    logic signed [KW-1:0] ea, eb, ec, ed;
    logic signed [KW-1:0] d3, d2, d1;
    logic signed [KW-1:0] k3_nxt, k2_nxt, k1_nxt, kc_nxt;
    logic signed [KW-1:0] k3_r, k2_r, k1_r;
    logic [CW+2:0]        kc_r;

    assign ca = $signed(pt_a_r[ax*CW +: CW]);
    assign cb = $signed(pt_b_r[ax*CW +: CW]);
    assign cc = $signed(pt_c_r[ax*CW +: CW]);
    assign cd = $signed(pt_d_r[ax*CW +: CW]);
    assign ea = KW'(ca);
    assign eb = KW'(cb);
    assign ec = KW'(cc);
    assign ed = KW'(cd);

    // (1-t)^3 A + (3t^3-6t^2+4) B + (-3t^3+3t^2+3t+1) C + t^3 D in powers of t
    assign d3     = eb - ec;
    assign d2     = ea - (eb <<< 1) + ec;
    assign d1     = ec - ea;
    assign k3_nxt = ed - ea + (d3 <<< 1) + d3;
    assign k2_nxt = (d2 <<< 1) + d2;
    assign k1_nxt = (d1 <<< 1) + d1;
    // constant term plus rounding half and the offset that keeps the quotient positive
    assign kc_nxt = ea + (eb <<< 2) + ec + KC_OFS;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        k3_r <= '0;
        k2_r <= '0;
        k1_r <= '0;
        kc_r <= KC_OFS[CW+2:0];
      end else begin
        k3_r <= k3_nxt;
        k2_r <= k2_nxt;
        k1_r <= k1_nxt;
        kc_r <= kc_nxt[CW+2:0];
      end
    end

    assign k3_o[ax] = k3_r;
    assign k2_o[ax] = k2_r;
    assign k1_o[ax] = k1_r;
    assign kc_o[ax] = kc_r;
  end

endmodule

@@ rtl/core/bsp_poly.sv @@
// ----------------------------------------------------------------------------
// bsp_poly - Horner evaluation pipeline for one axis
// Four stages: k3*u+k2, times u plus k1, split product by u, then floor
// division by S^3 with the constant term added. Output is the biased
// numerator of the final divide by six.
// ----------------------------------------------------------------------------
module bsp_poly #(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [T_FRAC_BITS:0]          u_in,
  input  logic signed [COORD_WIDTH+3:0] k3,
  input  logic signed [COORD_WIDTH+3:0] k2,
  input  logic signed [COORD_WIDTH+3:0] k1,
  input  logic [COORD_WIDTH+2:0]        kc,
  output logic [COORD_WIDTH+2:0]        qb_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int F   = T_FRAC_BITS;
  localparam int KW  = CW + 4;
  localparam int H1W = KW + F + 2;
  localparam int H2W = H1W + F + 2;
  localparam int HIW = H2W - F;
  localparam int HPW = HIW + F + 2;
  localparam int LPW = 2 * F + 1;
  localparam int QW  = CW + 3;

  // stage 1
  logic signed [F+1:0]  us0;
  logic signed [H1W-1:0] p1, h1_nxt, h1_r;
  logic [F:0]            u1_r;

  assign us0    = $signed({1'b0, u_in});
  assign p1     = k3 * us0;
  assign h1_nxt = p1 + (H1W'(k2) <<< F);

  always_ff @(posedge clk) begin
    if (en) begin
      h1_r <= h1_nxt;
      u1_r <= u_in;
    end
  end

  // stage 2
  logic signed [F+1:0]   us1;
  logic signed [H2W-1:0] p2, h2_nxt, h2_r;
  logic [F:0]            u2_r;

  assign us1    = $signed({1'b0, u1_r});
  assign p2     = h1_r * us1;
  assign h2_nxt = p2 + (H2W'(k1) <<< (2 * F));

  always_ff @(posedge clk) begin
    if (en) begin
      h2_r <= h2_nxt;
      u2_r <= u1_r;
    end
  end

  // stage 3: product split into high and low parts
  logic signed [F+1:0]   us2;
  logic signed [HIW-1:0] h2_hi;
  logic signed [HPW-1:0] phi_nxt, phi_r;
  logic [LPW-1:0]        plo_nxt, plo_r;

  assign us2     = $signed({1'b0, u2_r});
  assign h2_hi   = h2_r[H2W-1:F];
  assign phi_nxt = h2_hi * us2;
  assign plo_nxt = h2_r[F-1:0] * u2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      phi_r <= phi_nxt;
      plo_r <= plo_nxt;
    end
  end

  // stage 4: floor by S^3, constant term
  logic signed [HPW-1:0] sum;
  logic [QW-1:0]         qb_nxt, qb_r;

  assign sum    = phi_r + HPW'($signed({1'b0, plo_r[LPW-1:F]}));
  assign qb_nxt = sum[2*F +: QW] + kc;

  always_ff @(posedge clk) begin
    if (en) begin
      qb_r <= qb_nxt;
    end
  end

  assign qb_o = qb_r;

endmodule

@@ rtl/core/bsp_div6.sv @@
// ----------------------------------------------------------------------------
// bsp_div6 - divide by six and remove the offset
// Halves the biased value, divides by three through a reciprocal multiply,
// then flips the top bit back to two's complement.
// ----------------------------------------------------------------------------
module bsp_div6 #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [COORD_WIDTH+2:0] qb,
  output logic [COORD_WIDTH-1:0] res_o
);

  localparam int CW = COORD_WIDTH;
  localparam int XW = CW + 2;
  localparam int MW = CW + 3;
  localparam int SH = XW + 2;
  localparam logic [MW-1:0] RECIP3 = MW'((2 ** SH + 2) / 3);

  logic [XW+MW-1:0] prod_nxt, prod_r;
  logic [CW-1:0]    quo;
  logic [CW-1:0]    res_nxt, res_r;

  assign prod_nxt = qb[XW:1] * RECIP3;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign quo     = prod_r[SH +: CW];
  assign res_nxt = {~quo[CW-1], quo[CW-2:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

@@ rtl/core/cubic_bspline_point_3d_unit.sv @@
// ----------------------------------------------------------------------------
// cubic_bspline_point_3d_unit - uniform cubic B-spline point evaluator
// Evaluates one 3D point of a segment per parameter value.
//
// Control points A..D are written over the APB-style port (64-bit data,
// register i at byte address 8*i, x/y/z packed as signed fields). Each
// in_if transaction carries t in unsigned Q1.T_FRAC_BITS (values above one
// clamp to one); each out_if transaction returns the point x/y/z in signed
// Q8.8 at the default width, rounded to nearest.
// From acceptance to out_if.valid the pipeline has one input register,
// four Horner stages (multipliers in the first three) and two divide-by-six
// stages.
// Throughput is one transaction per cycle while the receiver does not stall.
// Reset clears the control points and all valid bits; coefficients reset to match.
// The pipeline advances as a whole; while the receiver stalls with a
// result waiting, in_if.ready is low and every stage holds its contents.
// A register write reaches the coefficients through the control point and coefficient registers.
// ----------------------------------------------------------------------------
module cubic_bspline_point_3d_unit #(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bsp_in_if.sink                         in_if,
  bsp_out_if.source                      out_if,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bsp_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [bsp_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [bsp_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int CW  = COORD_WIDTH;
  localparam int F   = T_FRAC_BITS;
  localparam int LAT = 7;
  localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

  logic signed [CW+3:0] k3 [bsp_pkg::NUM_AXES];
  logic signed [CW+3:0] k2 [bsp_pkg::NUM_AXES];
  logic signed [CW+3:0] k1 [bsp_pkg::NUM_AXES];
  logic [CW+2:0]        kc [bsp_pkg::NUM_AXES];
  logic [CW-1:0]        res [bsp_pkg::NUM_AXES];

  assign cfg_pready = 1'b1;

  bsp_cfg #(
    .COORD_WIDTH (CW)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .k3_o    (k3),
    .k2_o    (k2),
    .k1_o    (k1),
    .kc_o    (kc)
  );

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [F:0]     u_nxt, u_r;

  assign en          = !vld_r[LAT-1] || out_if.ready;
  assign in_if.ready = en;
  assign u_nxt       = (in_if.t_param > T_ONE) ? T_ONE : in_if.t_param;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_if.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= u_nxt;
    end
  end

  for (genvar ax = 0; ax < bsp_pkg::NUM_AXES; ax++) begin : g_axis
    logic [CW+2:0] qb;

    bsp_poly #(
      .COORD_WIDTH (CW),
      .T_FRAC_BITS (F)
    ) u_poly (
      .clk  (clk),
      .en   (en),
      .u_in (u_r),
      .k3   (k3[ax]),
      .k2   (k2[ax]),
      .k1   (k1[ax]),
      .kc   (kc[ax]),
      .qb_o (qb)
    );

    bsp_div6 #(
      .COORD_WIDTH (CW)
    ) u_div6 (
      .clk   (clk),
      .en    (en),
      .qb    (qb),
      .res_o (res[ax])
    );
  end

  assign out_if.valid = vld_r[LAT-1];
  assign out_if.out_x = $signed(res[0]);
  assign out_if.out_y = $signed(res[1]);
  assign out_if.out_z = $signed(res[2]);

endmodule
